// File: hdl/addr_tbl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// addr_tbl_pkg
// Shared sizes, codes and types of the address table with aging.
// ----------------------------------------------------------------------------
package addr_tbl_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 6;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((MAC_W + IP_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + 1 + 2 * COUNT_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(25000);

    localparam logic CMD_SEEN = 1'b0;
    localparam logic CMD_AGE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_AGED     = 2'd3;

    // result of the shared compare unit for one entry
    typedef struct packed {
        logic mac_eq;   // entry MAC equals the key
        logic aged;     // wrap-around age exceeds the timeout
    } cmp_res_t;

endpackage
`default_nettype wire

// File: hdl/addr_tbl_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// addr_tbl_cmp
// Shared compare unit: MAC match for lookups, age test for aging passes.
// ----------------------------------------------------------------------------
module addr_tbl_cmp (
    input  wire logic                             cmd,
    input  wire logic [addr_tbl_pkg::MAC_W-1:0]   key_mac,
    input  wire logic [addr_tbl_pkg::TIME_W-1:0]  now_ms,
    input  wire logic [addr_tbl_pkg::TIME_W-1:0]  timeout_ms,
    input  wire logic [addr_tbl_pkg::MAC_W-1:0]   ent_mac,
    input  wire logic [addr_tbl_pkg::TIME_W-1:0]  ent_last_seen,
    output addr_tbl_pkg::cmp_res_t                res
);
    import addr_tbl_pkg::*;

    logic [TIME_W-1:0] age;

    // modulo 2^32 age
    assign age = now_ms - ent_last_seen;

    always_comb begin
        res        = '0;
        res.mac_eq = (cmd == CMD_SEEN) && (ent_mac == key_mac);
        res.aged   = (cmd == CMD_AGE) && (age > timeout_ms);
    end

endmodule
`default_nettype wire

// File: hdl/address_table_with_aging.sv
`default_nettype none
// ----------------------------------------------------------------------------
// address_table_with_aging
// Node table keyed by MAC address, with lookup/insert and timeout aging.
// ----------------------------------------------------------------------------
// One item is processed at a time. After the input transfer the sequencer
// reads the table one entry per cycle through the shared compare unit,
// compares the last read in ST_LAST, then does the write-back in ST_WRITE
// and loads the result register. The next input transfer waits until the
// result has been transferred, so items never overlap; the spacing is set
// by the entry memories read one entry at a time and the one compare unit,
// and a stalled result register holds off the next item. s_tready is high
// only while the sequencer is idle and the result register is empty.
// A seen item (tuser = 0) updates a matching entry or fills the lowest free
// slot; when the table is full it is dropped with status 2. An age item
// (tuser = 1) marks offline every used entry whose age exceeds the timeout
// register. Used and online counts are kept in counters, updated as entries
// change. No clearing pass: used and online bits sit in flops cleared by
// reset, the MAC, IP and time words are only read behind a set used bit.
// ----------------------------------------------------------------------------
module address_table_with_aging (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input: [47:0] node_mac, [79:48] node_ip, [111:80] now_ms
    input  wire logic [addr_tbl_pkg::S_TDATA_W-1:0]   s_tdata,
    // input tuser: [0] cmd
    input  wire logic                                 s_tuser,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // result: [4:0] slot_index, [5] probe_needed, [11:6] used_count,
    //         [17:12] online_count, [23:18] zero
    output logic [addr_tbl_pkg::M_TDATA_W-1:0]        m_tdata,
    // result tuser: [1:0] status
    output logic [addr_tbl_pkg::STATUS_W-1:0]         m_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // config: offline_timeout_ms at address 0
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);
    import addr_tbl_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_LAST  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // sequencer
    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;

    // table flags and counters
    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] online_reg;
    logic [CNT_W-1:0]         used_cnt_reg;
    logic [CNT_W-1:0]         online_cnt_reg;

    // entry memories
    logic [MAC_W-1:0]  entry_mac  [TABLE_ENTRIES];
    logic [IP_W-1:0]   entry_ip   [TABLE_ENTRIES];
    logic [TIME_W-1:0] entry_seen [TABLE_ENTRIES];
    logic [MAC_W-1:0]  mac_rd_reg;
    logic [IP_W-1:0]   ip_rd_reg;
    logic [TIME_W-1:0] seen_rd_reg;

    // captured item
    logic              cmd_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [TIME_W-1:0] now_reg;

    // scan results
    logic              hit_found_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [IP_W-1:0]   hit_ip_reg;

    // result register
    logic                 m_tvalid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 probe_reg;

    logic [TIME_W-1:0] timeout_reg;

    logic      s_fire;
    logic      cfg_wr;
    logic      wb_hit;
    logic      wb_ins;
    cmp_res_t  cmp_res;

    assign s_fire = s_tvalid && s_tready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // write-back decisions, valid in ST_WRITE for a seen item
    assign wb_hit = (state_reg == ST_WRITE) && (cmd_reg == CMD_SEEN) && hit_found_reg;
    assign wb_ins = (state_reg == ST_WRITE) && (cmd_reg == CMD_SEEN) &&
                    !hit_found_reg && free_found_reg;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? timeout_reg : 32'd0;

    // ---------------- shared compare unit ----------------
    addr_tbl_cmp u_cmp (
        .cmd           (cmd_reg),
        .key_mac       (mac_reg),
        .now_ms        (now_reg),
        .timeout_ms    (timeout_reg),
        .ent_mac       (mac_rd_reg),
        .ent_last_seen (seen_rd_reg),
        .res           (cmp_res)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                rd_idx_next = '0;
                if (s_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = ST_LAST;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_LAST: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid_reg;

    // ---------------- control state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            used_reg       <= '0;
            online_reg     <= '0;
            used_cnt_reg   <= '0;
            online_cnt_reg <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
        end else begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            // read issued in ST_SCAN is compared in the next cycle
            cmp_vld_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg <= rd_idx_reg;

            if (cfg_wr && (paddr[2] == 1'b0)) begin
                timeout_reg <= pwdata;
            end

            if (s_fire) begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end

            if (cmp_vld_reg) begin
                if (cmd_reg == CMD_AGE) begin
                    if (used_reg[cmp_idx_reg] && cmp_res.aged) begin
                        online_reg[cmp_idx_reg] <= 1'b0;
                        if (online_reg[cmp_idx_reg]) begin
                            online_cnt_reg <= online_cnt_reg - 1'b1;
                        end
                    end
                end else if (used_reg[cmp_idx_reg]) begin
                    if (cmp_res.mac_eq) begin
                        hit_found_reg <= 1'b1;
                    end
                end else begin
                    free_found_reg <= 1'b1;
                end
            end

            if (wb_hit) begin
                online_reg[hit_idx_reg] <= 1'b1;
                if (!online_reg[hit_idx_reg]) begin
                    online_cnt_reg <= online_cnt_reg + 1'b1;
                end
            end
            if (wb_ins) begin
                used_reg[free_idx_reg]   <= 1'b1;
                online_reg[free_idx_reg] <= 1'b1;
                used_cnt_reg             <= used_cnt_reg + 1'b1;
                online_cnt_reg           <= online_cnt_reg + 1'b1;
            end

            if (state_reg == ST_WRITE) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= s_tuser;
            mac_reg <= s_tdata[MAC_W-1:0];
            ip_reg  <= s_tdata[MAC_W+IP_W-1:MAC_W];
            now_reg <= s_tdata[MAC_W+IP_W+TIME_W-1:MAC_W+IP_W];
        end

        // first match and first free slot win
        if (cmp_vld_reg && (cmd_reg == CMD_SEEN)) begin
            if (used_reg[cmp_idx_reg]) begin
                if (!hit_found_reg && cmp_res.mac_eq) begin
                    hit_idx_reg <= cmp_idx_reg;
                    hit_ip_reg  <= ip_rd_reg;
                end
            end else if (!free_found_reg) begin
                free_idx_reg <= cmp_idx_reg;
            end
        end

        if (state_reg == ST_WRITE) begin
            if (cmd_reg == CMD_AGE) begin
                status_reg <= STATUS_AGED;
                slot_reg   <= '0;
                probe_reg  <= 1'b0;
            end else if (hit_found_reg) begin
                status_reg <= STATUS_UPDATED;
                slot_reg   <= SLOT_W'(hit_idx_reg);
                probe_reg  <= (hit_ip_reg != ip_reg);
            end else if (free_found_reg) begin
                status_reg <= STATUS_INSERTED;
                slot_reg   <= SLOT_W'(free_idx_reg);
                probe_reg  <= 1'b1;
            end else begin
                status_reg <= STATUS_DROPPED;
                slot_reg   <= '0;
                probe_reg  <= 1'b0;
            end
        end
    end

    // ---------------- entry memories ----------------
    always_ff @(posedge aclk) begin
        mac_rd_reg  <= entry_mac[rd_idx_reg];
        ip_rd_reg   <= entry_ip[rd_idx_reg];
        seen_rd_reg <= entry_seen[rd_idx_reg];

        if (wb_ins) begin
            entry_mac[free_idx_reg]  <= mac_reg;
            entry_ip[free_idx_reg]   <= ip_reg;
            entry_seen[free_idx_reg] <= now_reg;
        end
        if (wb_hit) begin
            entry_ip[hit_idx_reg]   <= ip_reg;
            entry_seen[hit_idx_reg] <= now_reg;
        end
    end

    // ---------------- result channel ----------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_TDATA_W'({COUNT_W'(online_cnt_reg), COUNT_W'(used_cnt_reg),
                                  probe_reg, slot_reg});

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for address_table_with_aging: drives seen and age
// transfers on the input stream, predicts the node table in the bench and
// compares every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import addr_tbl_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE   = 24;     // MACs that recur, so lookups hit
    localparam int DRAIN_WAIT  = 40;     // a little over one item's latency
    localparam int HOLD_AT     = 250;    // result count that starts the long stall
    localparam int HOLD_CYCLES = 400;

    // register map: index i sits at byte address 4*i
    localparam int REG_OFFLINE_TIMEOUT = 0;
    localparam int REG_UNMAPPED        = 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                probe;
        logic [COUNT_W-1:0]  used;
        logic [COUNT_W-1:0]  online;
    } node_result_t;

    typedef struct packed {
        logic          cmd;
        logic [47:0]   mac;
        logic [31:0]   ip;
        logic [31:0]   now;
        logic          typed;    // expectation given in the row itself
        node_result_t  res;
    } stim_row_t;

    localparam int N_ROWS = 12;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    address_table_with_aging dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Bench copy of the node table and the timeout register
    // ------------------------------------------------------------------
    logic              tbl_used   [TABLE_ENTRIES];
    logic [MAC_W-1:0]  tbl_mac    [TABLE_ENTRIES];
    logic [IP_W-1:0]   tbl_ip     [TABLE_ENTRIES];
    logic [TIME_W-1:0] tbl_seen   [TABLE_ENTRIES];
    logic              tbl_online [TABLE_ENTRIES];
    logic [TIME_W-1:0] tbl_timeout;

    node_result_t pending_results[$];

    int          fail_count   = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    int          hold_left    = 0;
    bit          hold_done    = 0;
    logic [47:0] pool_mac [POOL_SIZE];
    logic [31:0] pool_ip  [POOL_SIZE];
    logic [31:0] clock_ms;
    stim_row_t   directed_rows [N_ROWS];

    // no idling on either side across this stretch of transfers
    wire steady = (items_sent >= 500) && (items_sent < 650);

    // Apply one item to the bench table, return the result it must produce.
    function automatic node_result_t table_step(input logic cmd, input logic [47:0] mac,
                                                input logic [31:0] ip,
                                                input logic [31:0] now);
        node_result_t r;
        int hit;
        int free_slot;
        int n_used;
        int n_online;
        logic [31:0] age;
        r = '0;
        hit = -1;
        free_slot = -1;
        n_used = 0;
        n_online = 0;
        if (cmd == CMD_AGE) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                age = now - tbl_seen[i];    // wraps modulo 2^32
                if (tbl_used[i] && age > tbl_timeout)
                    tbl_online[i] = 1'b0;
            end
            r.status = STATUS_AGED;
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_used[i]) begin
                    if (hit < 0 && tbl_mac[i] == mac)
                        hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                tbl_seen[hit]   = now;
                tbl_online[hit] = 1'b1;
                if (tbl_ip[hit] != ip) begin
                    tbl_ip[hit] = ip;
                    r.probe = 1'b1;
                end
                r.status = STATUS_UPDATED;
                r.slot   = SLOT_W'(hit);
            end else if (free_slot >= 0) begin
                tbl_used[free_slot]   = 1'b1;
                tbl_mac[free_slot]    = mac;
                tbl_ip[free_slot]     = ip;
                tbl_seen[free_slot]   = now;
                tbl_online[free_slot] = 1'b1;
                r.probe  = 1'b1;
                r.status = STATUS_INSERTED;
                r.slot   = SLOT_W'(free_slot);
            end else begin
                r.status = STATUS_DROPPED;    // table full, nothing changes
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_used[i]) begin
                n_used++;
                if (tbl_online[i])
                    n_online++;
            end
        end
        r.used   = COUNT_W'(n_used);
        r.online = COUNT_W'(n_online);
        return r;
    endfunction

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // ------------------------------------------------------------------
    // Input side: called at a falling edge, returns at a falling edge with
    // s_tvalid still high so back-to-back transfers never drop valid.
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [47:0] mac, input logic [31:0] ip,
                             input logic [31:0] now, input logic typed,
                             input node_result_t typed_res);
        node_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {now, ip, mac};
        do @(posedge aclk); while (!s_tready);
        predicted = table_step(cmd, mac, ip, now);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    // drop valid, wait for every expected result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // APB setup + access + an idle phase; a read is checked against the
    // bench register
    task automatic reg_access(input logic wr, input int index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 3'(4 * index);
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (wr) begin
            if (index == REG_OFFLINE_TIMEOUT)
                tbl_timeout = data;    // odd indexes are ignored by the block
        end else if (prdata !== tbl_timeout) begin
            $display("%0t: prdata expected %0h, got %0h", $time, tbl_timeout, prdata);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_timeout(input logic [31:0] value);
        reg_access(1'b1, REG_OFFLINE_TIMEOUT, value);
        reg_access(1'b0, REG_OFFLINE_TIMEOUT, '0);
    endtask

    // millisecond clock: mostly small steps, some past the timeout, rare jumps
    task automatic advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            clock_ms = $urandom;
        else if (r < 20)
            clock_ms = clock_ms + $urandom_range(20000, 40000);
        else
            clock_ms = clock_ms + $urandom_range(0, 2000);
    endtask

    // Random traffic: mostly recurring nodes (hits, IP changes), some fresh
    // MACs that fill the table and then get dropped, and aging ticks.
    task automatic run_random(input int count);
        int r;
        int k;
        repeat (count) begin
            advance_clock();
            r = $urandom_range(0, 99);
            if (r < 14) begin
                send_item(CMD_AGE, rand_mac(), $urandom, clock_ms, 1'b0, '0);
            end else if (r < 26) begin
                send_item(CMD_SEEN, rand_mac(), $urandom, clock_ms, 1'b0, '0);
            end else begin
                k = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 3) == 0)
                    pool_ip[k] = $urandom;
                send_item(CMD_SEEN, pool_mac[k], pool_ip[k], clock_ms, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready changes at the falling edge; one long stall lets
    // the result register fill and back up the input.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        node_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0h / %0h",
                         $time, m_tuser, m_tdata);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("status", 32'(exp_r.status), 32'(m_tuser));
                check_field("slot_index", 32'(exp_r.slot), 32'(m_tdata[4:0]));
                check_field("probe_needed", 32'(exp_r.probe), 32'(m_tdata[5]));
                check_field("used_count", 32'(exp_r.used), 32'(m_tdata[11:6]));
                check_field("online_count", 32'(exp_r.online), 32'(m_tdata[17:12]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tvalid = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        clock_ms = '0;
        tbl_timeout = TIMEOUT_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_used[i]   = 1'b0;
            tbl_online[i] = 1'b0;
            tbl_mac[i]    = '0;
            tbl_ip[i]     = '0;
            tbl_seen[i]   = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_mac[i] = rand_mac();
            pool_ip[i]  = $urandom;
        end

        // Directed rows, timeout at its reset value. Typed expectations:
        // empty-table aging, extreme MAC/IP/time inserts, hit without and
        // with IP change, age exactly at the timeout (stays online) and one
        // past it, wrap-around of the millisecond time.
        directed_rows = '{
            '{CMD_AGE,  48'h0, 32'h0, 32'h0, 1'b1,
              '{STATUS_AGED,     5'd0, 1'b0, 6'd0, 6'd0}},
            '{CMD_SEEN, 48'h0, 32'h0, 32'h0, 1'b1,
              '{STATUS_INSERTED, 5'd0, 1'b1, 6'd1, 6'd1}},
            '{CMD_SEEN, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{STATUS_INSERTED, 5'd1, 1'b1, 6'd2, 6'd2}},
            '{CMD_SEEN, 48'h0, 32'h0, 32'd100, 1'b1,
              '{STATUS_UPDATED,  5'd0, 1'b0, 6'd2, 6'd2}},
            '{CMD_SEEN, 48'h0, 32'h1, 32'd200, 1'b1,
              '{STATUS_UPDATED,  5'd0, 1'b1, 6'd2, 6'd2}},
            // slot 0 is exactly 25000 old, slot 1 is 25201 old (wrapped)
            '{CMD_AGE,  48'h0, 32'h0, 32'd25200, 1'b1,
              '{STATUS_AGED,     5'd0, 1'b0, 6'd2, 6'd1}},
            '{CMD_AGE,  48'h0, 32'h0, 32'd25201, 1'b1,
              '{STATUS_AGED,     5'd0, 1'b0, 6'd2, 6'd0}},
            '{CMD_SEEN, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd30000, 1'b1,
              '{STATUS_UPDATED,  5'd1, 1'b0, 6'd2, 6'd1}},
            '{CMD_SEEN, 48'h1234_5678_9ABC, 32'hC0A8_0001, 32'hFFFF_FF00, 1'b0, '0},
            '{CMD_SEEN, 48'h8000_0000_0001, 32'h8000_0000, 32'hFFFF_FFF0, 1'b0, '0},
            '{CMD_AGE,  48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0100, 1'b0, '0},
            '{CMD_SEEN, 48'h0, 32'h1, 32'h0000_0200, 1'b0, '0}
        };

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // register reads back its reset value before any write
        reg_access(1'b0, REG_OFFLINE_TIMEOUT, '0);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].mac, directed_rows[i].ip,
                      directed_rows[i].now, directed_rows[i].typed, directed_rows[i].res);
        clock_ms = 32'h0000_0200;
        drain();

        // zero timeout: anything older than 0 ms goes offline; also a write
        // to an unmapped index, which must leave the timeout untouched
        set_timeout('0);
        reg_access(1'b1, REG_UNMAPPED, 32'hA5A5_5A5A);
        reg_access(1'b0, REG_OFFLINE_TIMEOUT, '0);
        run_random(280);
        drain();

        // maximum timeout: nothing ever ages out
        set_timeout(32'hFFFF_FFFF);
        run_random(280);
        drain();

        set_timeout($urandom_range(500, 30000));
        run_random(280);
        drain();

        set_timeout(32'd1000);
        run_random(300);
        drain();

        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/addr_tbl_pkg.sv
hdl/addr_tbl_cmp.sv
hdl/address_table_with_aging.sv
sim/tb.sv
